// ===== rtl/rhrb_pkg.sv =====
// Shared types and constants for the record history ring buffer.
// No dependencies; every other file of the block depends on this package.
`default_nettype none
package rhrb_pkg;

  localparam int UPTIME_W  = 32;
  localparam int PAYLOAD_W = 64;
  localparam int FLAGS_W   = 8;
  localparam int CAP_W     = 7;
  localparam int COUNT_W   = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_STORE  = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_LATEST = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [UPTIME_W-1:0]  uptime;
    logic [PAYLOAD_W-1:0] payload;
    logic [FLAGS_W-1:0]   flags;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/rhrb_ifs.sv =====
// Channel interfaces of the record history ring buffer: input items,
// result items and the capacity write channel. Depends on rhrb_pkg.
`default_nettype none
interface rhrb_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [rhrb_pkg::UPTIME_W-1:0]  rec_uptime;
  logic [rhrb_pkg::PAYLOAD_W-1:0] rec_payload;
  logic [rhrb_pkg::FLAGS_W-1:0]   rec_flags;
  logic                           rec_ok;
  logic [rhrb_pkg::UPTIME_W-1:0]  range_start;
  logic [rhrb_pkg::UPTIME_W-1:0]  range_end;
  logic [rhrb_pkg::COUNT_W-1:0]   latest_count;

  modport source (output valid, kind, rec_uptime, rec_payload, rec_flags, rec_ok,
                  range_start, range_end, latest_count, input ready);
  modport sink (input valid, kind, rec_uptime, rec_payload, rec_flags, rec_ok,
                range_start, range_end, latest_count, output ready);
endinterface

interface rhrb_out_if;
  logic                           valid;
  logic                           ready;
  logic                           has_record;
  logic [rhrb_pkg::UPTIME_W-1:0]  out_uptime;
  logic [rhrb_pkg::PAYLOAD_W-1:0] out_payload;
  logic [rhrb_pkg::FLAGS_W-1:0]   out_flags;
  logic                           store_accepted;
  logic                           last;

  modport source (output valid, has_record, out_uptime, out_payload, out_flags,
                  store_accepted, last, input ready);
  modport sink (input valid, has_record, out_uptime, out_payload, out_flags,
                store_accepted, last, output ready);
endinterface

interface rhrb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rhrb_pkg::CAP_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rhrb_mem.sv =====
// Record slot memory: one write port, one read port with registered data.
// Depends on rhrb_pkg for the record type.
`default_nettype none
module rhrb_mem #(
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire rhrb_pkg::rec_t             wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output rhrb_pkg::rec_t                  rdata
);
  import rhrb_pkg::*;

  rec_t slots [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      slots[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= slots[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rhrb_ctrl.sv =====
// Sequencer of the record history ring buffer: ring pointers, store and
// clear handling, query walk over the slot memory, output register.
// Depends on rhrb_pkg and rhrb_ifs.
`default_nettype none
module rhrb_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  rhrb_in_if.sink                         in,
  rhrb_out_if.source                      out,
  rhrb_cfg_if.sink                        cfg,
  output logic                            mem_we,
  output logic [$clog2(DEPTH)-1:0]        mem_waddr,
  output rhrb_pkg::rec_t                  mem_wdata,
  output logic                            mem_re,
  output logic [$clog2(DEPTH)-1:0]        mem_raddr,
  input  wire rhrb_pkg::rec_t             mem_rdata
);
  import rhrb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  // Capacity 0 acts as 1, anything above the memory depth acts as the depth.
  function automatic logic [CW-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [XW-1:0] ve;
    ve = XW'(v);
    if (ve == '0) begin
      return CW'(1);
    end else if (ve > XW'(DEPTH)) begin
      return CW'(DEPTH);
    end
    return CW'(ve);
  endfunction

  state_t state, state_next;

  logic [CW-1:0] cap;
  logic [CW-1:0] fill;
  logic [AW-1:0] wp;
  logic [AW-1:0] oldest;
  logic          wrapped;

  logic [AW-1:0]       raddr;
  logic [CW-1:0]       remaining;
  logic                mode_latest;
  logic [UPTIME_W-1:0] lo;
  logic [UPTIME_W-1:0] hi;
  logic                dvalid;
  logic                pend_v;
  rec_t                pend;

  logic out_v;
  logic out_has;
  rec_t out_rec;
  logic out_acc;
  logic out_last;

  logic          out_free;
  logic          in_ready;
  logic          in_fire;
  logic          cfg_fire;
  kind_t         kind;
  logic          store_ok;
  logic [AW-1:0] wp_inc;
  logic [AW-1:0] raddr_inc;
  logic          match;
  logic [CW-1:0] n_lat;
  logic [CW-1:0] wp_c;
  logic [AW-1:0] lat_start;
  logic          rd_en;
  logic          consume;
  logic          fin_push;

  assign out_free = !out_v || out.ready;
  assign in_fire  = in.valid && in_ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign kind     = kind_t'(in.kind);
  assign store_ok = (in.rec_uptime != '0) && (in.rec_flags != '0) && in.rec_ok;

  assign wp_inc    = ((CW'(wp) + CW'(1)) == cap) ? '0 : wp + AW'(1);
  assign raddr_inc = ((CW'(raddr) + CW'(1)) == cap) ? '0 : raddr + AW'(1);

  assign match = mode_latest || ((mem_rdata.uptime >= lo) && (mem_rdata.uptime <= hi));

  // Newest n records start n slots behind the write pointer, modulo capacity.
  assign n_lat     = (XW'(in.latest_count) < XW'(fill)) ? CW'(in.latest_count) : fill;
  assign wp_c      = CW'(wp);
  assign lat_start = (wp_c >= n_lat) ? AW'(wp_c - n_lat) : AW'(wp_c + cap - n_lat);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (kind == KIND_RANGE || kind == KIND_LATEST)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (remaining == '0 && !dvalid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    consume  = 1'b0;
    rd_en    = 1'b0;
    fin_push = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = out_free;
      end
      ST_SCAN: begin
        consume = dvalid && (!match || !pend_v || out_free);
        rd_en   = (remaining != '0) && (!dvalid || consume);
      end
      ST_FINISH: begin
        fin_push = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in.ready = in_ready;
  assign cfg.ready = 1'b1;

  assign mem_we            = in_fire && (kind == KIND_STORE) && store_ok;
  assign mem_waddr         = wp;
  assign mem_wdata.uptime  = in.rec_uptime;
  assign mem_wdata.payload = in.rec_payload;
  assign mem_wdata.flags   = in.rec_flags;
  assign mem_re            = rd_en;
  assign mem_raddr         = raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cap     <= clamp_cap(CAP_RESET);
      fill    <= '0;
      wp      <= '0;
      oldest  <= '0;
      wrapped <= 1'b0;
      dvalid  <= 1'b0;
      pend_v  <= 1'b0;
      out_v   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_fire) begin
        cap     <= clamp_cap(cfg.data);
        fill    <= '0;
        wp      <= '0;
        oldest  <= '0;
        wrapped <= 1'b0;
      end else if (in_fire) begin
        case (kind)
          KIND_STORE: begin
            if (store_ok) begin
              wp <= wp_inc;
              if (fill < cap) begin
                fill <= fill + CW'(1);
              end else begin
                wrapped <= 1'b1;
                oldest  <= wp_inc;
              end
            end
          end
          KIND_CLEAR: begin
            fill    <= '0;
            wp      <= '0;
            oldest  <= '0;
            wrapped <= 1'b0;
          end
          KIND_RANGE: begin
            mode_latest <= 1'b0;
            lo          <= in.range_start;
            hi          <= in.range_end;
            raddr       <= wrapped ? oldest : '0;
            remaining   <= fill;
          end
          KIND_LATEST: begin
            mode_latest <= 1'b1;
            raddr       <= lat_start;
            remaining   <= n_lat;
          end
          default: begin
            mode_latest <= mode_latest;
          end
        endcase
      end

      if (rd_en) begin
        raddr     <= raddr_inc;
        remaining <= remaining - CW'(1);
        dvalid    <= 1'b1;
      end else if (consume) begin
        dvalid <= 1'b0;
      end

      if (consume && match) begin
        pend   <= mem_rdata;
        pend_v <= 1'b1;
      end else if (fin_push) begin
        pend_v <= 1'b0;
      end

      // A new result takes the output register; otherwise a taken result empties it.
      if (in_fire && (kind == KIND_STORE || kind == KIND_CLEAR)) begin
        out_v    <= 1'b1;
        out_has  <= 1'b0;
        out_rec  <= '0;
        out_acc  <= (kind == KIND_CLEAR) ? 1'b1 : store_ok;
        out_last <= 1'b1;
      end else if (consume && match && pend_v) begin
        out_v    <= 1'b1;
        out_has  <= 1'b1;
        out_rec  <= pend;
        out_acc  <= 1'b0;
        out_last <= 1'b0;
      end else if (fin_push) begin
        out_v    <= 1'b1;
        out_has  <= pend_v;
        out_rec  <= pend_v ? pend : '0;
        out_acc  <= 1'b0;
        out_last <= 1'b1;
      end else if (out_v && out.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  assign out.valid          = out_v;
  assign out.has_record     = out_has;
  assign out.out_uptime     = out_rec.uptime;
  assign out.out_payload    = out_rec.payload;
  assign out.out_flags      = out_rec.flags;
  assign out.store_accepted = out_acc;
  assign out.last           = out_last;

endmodule
`default_nettype wire

// ===== rtl/record_history_ring_buffer_top.sv =====
// Store and clear items give a result that is registered the cycle after acceptance,
// and such items can follow back to back while the output drains.
// A query walking N slots (the fill level for a range, the returned count for latest)
// reads one slot per cycle while the output does not stall, registers its final result
// from the finish state, and the next item is taken once the sequencer is idle again.
// Reset empties the store and sets capacity to 64; slot contents are not cleared.
`default_nettype none
module record_history_ring_buffer_top #(
  parameter int DEPTH = 64
) (
  input wire logic    clk,
  input wire logic    rst,
  rhrb_in_if.sink     in,
  rhrb_out_if.source  out,
  rhrb_cfg_if.sink    cfg
);
  import rhrb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // Slot memory port signals between the sequencer and the memory.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rec_t          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  rec_t          mem_rdata;

  // The sequencer owns all control state. A query walks the stored slots oldest first,
  // holding each matching record back by one so that the final one can carry the last
  // mark; a query with no match ends in a single empty result.
  rhrb_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in        (in),
    .out       (out),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // The records themselves live in one synchronous memory. Writes happen only when
  // a store is accepted and reads only during a query walk, so the ports never
  // touch the same slot in the same cycle.
  rhrb_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for record_history_ring_buffer_top: a clocked driver, a clocked
// monitor and a shadow copy of the ring store that predicts every result item.
// Depends on rtl/rhrb_pkg.sv, rtl/rhrb_ifs.sv and the block's RTL.

module tb_top;
  import rhrb_pkg::*;

  localparam int DEPTH        = 64;
  // Extra cycles after the last result cover any bookkeeping the block still does.
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 200;

  // One input item as the driver puts it on the channel.
  typedef struct packed {
    kind_t                kind;
    logic [UPTIME_W-1:0]  rec_uptime;
    logic [PAYLOAD_W-1:0] rec_payload;
    logic [FLAGS_W-1:0]   rec_flags;
    logic                 rec_ok;
    logic [UPTIME_W-1:0]  range_start;
    logic [UPTIME_W-1:0]  range_end;
    logic [COUNT_W-1:0]   latest_count;
  } item_t;

  // One result item, in the same field order the monitor packs from the channel.
  typedef struct packed {
    logic                 has_record;
    logic [UPTIME_W-1:0]  uptime;
    logic [PAYLOAD_W-1:0] payload;
    logic [FLAGS_W-1:0]   flags;
    logic                 store_accepted;
    logic                 last;
  } result_t;

  logic clk;
  logic rst;

  rhrb_in_if  item_ch ();
  rhrb_out_if result_ch ();
  rhrb_cfg_if cap_ch ();

  record_history_ring_buffer_top #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .in  (item_ch),
    .out (result_ch),
    .cfg (cap_ch)
  );

  // Items waiting to be driven, and results that the shadow store says must come back.
  item_t   pending_items[$];
  result_t expected_results[$];
  int      mismatch_count = 0;

  // Shadow of the ring store: slots, pointers, fill level and the capacity register.
  rec_t             shadow_slot [DEPTH];
  int unsigned      shadow_fill;
  int unsigned      shadow_wptr;
  int unsigned      shadow_optr;
  bit               shadow_wrapped;
  logic [CAP_W-1:0] shadow_cap;

  // Running uptime used to build realistic, mostly increasing record stamps.
  logic [UPTIME_W-1:0] uptime_clock;

  // Clock, reset and known values on every input from time zero.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.kind         = KIND_STORE;
    item_ch.rec_uptime   = '0;
    item_ch.rec_payload  = '0;
    item_ch.rec_flags    = '0;
    item_ch.rec_ok       = 1'b0;
    item_ch.range_start  = '0;
    item_ch.range_end    = '0;
    item_ch.latest_count = '0;
    result_ch.ready      = 1'b0;
    cap_ch.valid         = 1'b0;
    cap_ch.data          = '0;
    forever #2 clk = ~clk;
  end

  // Emptying the store: on a clear item and on every capacity write.
  function automatic void empty_shadow();
    shadow_fill    = 0;
    shadow_wptr    = 0;
    shadow_optr    = 0;
    shadow_wrapped = 1'b0;
  endfunction

  // Appends one item to the driver's queue.
  function automatic void add_pending(item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Appends one result to the list of results still to come.
  function automatic void add_expected(result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Works out every result that one accepted item causes and appends them, in order,
  // to expected_results. Store and clear items give one result; queries give one
  // result per matching record, or a single empty result when nothing matches.
  function automatic void predict_results(item_t it);
    int unsigned cap;
    int unsigned start;
    int unsigned idx;
    int unsigned n;
    int unsigned i;
    result_t     r;
    result_t     batch[$];

    // A capacity of zero behaves as one, anything above the depth as the depth.
    if (shadow_cap == 0)
      cap = 1;
    else if (shadow_cap > DEPTH)
      cap = DEPTH;
    else
      cap = 32'(shadow_cap);
    if (shadow_wptr >= cap) shadow_wptr = 0;
    if (shadow_optr >= cap) shadow_optr = 0;

    r = '0;
    r.last = 1'b1;
    case (it.kind)
      KIND_STORE: begin
        // A record needs a nonzero stamp, nonzero flags and its own check passed.
        r.store_accepted = (it.rec_uptime != 0) && (it.rec_flags != 0) && it.rec_ok;
        if (r.store_accepted) begin
          shadow_slot[shadow_wptr] = '{uptime: it.rec_uptime, payload: it.rec_payload,
                                       flags: it.rec_flags};
          shadow_wptr = (shadow_wptr + 1) % cap;
          if (shadow_fill < cap) begin
            shadow_fill++;
          end else begin
            // Full: the new record took the oldest slot, so the oldest moves on.
            shadow_wrapped = 1'b1;
            shadow_optr    = shadow_wptr;
          end
        end
        add_expected(r);
      end
      KIND_CLEAR: begin
        empty_shadow();
        r.store_accepted = 1'b1;
        add_expected(r);
      end
      default: begin
        if (it.kind == KIND_RANGE) begin
          // Walk from the oldest record and keep those inside the inclusive bounds.
          start = shadow_wrapped ? shadow_optr : 0;
          for (i = 0; i < shadow_fill && i < cap; i++) begin
            idx = (start + i) % cap;
            if (shadow_slot[idx].uptime >= it.range_start &&
                shadow_slot[idx].uptime <= it.range_end)
              batch = {batch, result_t'({1'b1, shadow_slot[idx], 1'b0, 1'b0})};
          end
        end else begin
          // The newest n records, still oldest first.
          n = (32'(it.latest_count) < shadow_fill) ? 32'(it.latest_count) : shadow_fill;
          if (n > cap) n = cap;
          for (i = 0; i < n; i++) begin
            idx = (shadow_wptr + cap - n + i) % cap;
            batch = {batch, result_t'({1'b1, shadow_slot[idx], 1'b0, 1'b0})};
          end
        end
        if (batch.size() == 0) begin
          add_expected(r);
        end else begin
          batch[batch.size() - 1].last = 1'b1;
          foreach (batch[j]) add_expected(batch[j]);
        end
      end
    endcase
  endfunction

  // Driver. Items go out in bursts of random length separated by random gaps, and an
  // item on the channel is held unchanged until the block takes it. The accepted item
  // is handed to the shadow store at the very edge where the handshake completes.
  item_t cur_item;
  int    burst_left;
  int    gap_left;

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 16);
      gap_left   = 0;
    end else begin
      if (item_ch.valid && item_ch.ready)
        predict_results(cur_item);
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          item_ch.kind         <= cur_item.kind;
          item_ch.rec_uptime   <= cur_item.rec_uptime;
          item_ch.rec_payload  <= cur_item.rec_payload;
          item_ch.rec_flags    <= cur_item.rec_flags;
          item_ch.rec_ok       <= cur_item.rec_ok;
          item_ch.range_start  <= cur_item.range_start;
          item_ch.range_end    <= cur_item.range_end;
          item_ch.latest_count <= cur_item.latest_count;
          item_ch.valid        <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // About a third of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result taken from the block is compared with the oldest expectation.
  // The ready pattern moves through four modes in turn: always ready, coin flips, a sparse
  // periodic pattern, and mostly ready with short random stalls.
  int unsigned stall_tick = 0;
  result_t     got;
  result_t     want;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = {result_ch.has_record, result_ch.out_uptime, result_ch.out_payload,
               result_ch.out_flags, result_ch.store_accepted, result_ch.last};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: unexpected result, expected none, ", $time,
                     "got rec=%0b up=%h pay=%h fl=%h acc=%0b last=%0b",
                     got.has_record, got.uptime, got.payload, got.flags,
                     got.store_accepted, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t ns: result mismatch, ", $time,
                       "expected rec=%0b up=%h pay=%h fl=%h acc=%0b last=%0b, ",
                       want.has_record, want.uptime, want.payload, want.flags,
                       want.store_accepted, want.last,
                       "got rec=%0b up=%h pay=%h fl=%h acc=%0b last=%0b",
                       got.has_record, got.uptime, got.payload, got.flags,
                       got.store_accepted, got.last);
          end
        end
      end
      stall_tick++;
      case ((stall_tick / 256) % 4)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= 1'($urandom_range(0, 1));
        2:       result_ch.ready <= (stall_tick % 4 == 3);
        default: result_ch.ready <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  // Item builders. Fields that the item's kind does not use carry random values, so
  // the block is also shown that it ignores them.
  function automatic item_t noise_item();
    item_t it;
    it.kind         = kind_t'($urandom_range(0, 3));
    it.rec_uptime   = $urandom;
    it.rec_payload  = {$urandom, $urandom};
    it.rec_flags    = 8'($urandom_range(0, 255));
    it.rec_ok       = 1'($urandom_range(0, 1));
    it.range_start  = $urandom;
    it.range_end    = $urandom;
    it.latest_count = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic void queue_store(logic [UPTIME_W-1:0] up, logic [PAYLOAD_W-1:0] pay,
                                      logic [FLAGS_W-1:0] fl, logic ok);
    item_t it;
    it = noise_item();
    it.kind        = KIND_STORE;
    it.rec_uptime  = up;
    it.rec_payload = pay;
    it.rec_flags   = fl;
    it.rec_ok      = ok;
    add_pending(it);
  endfunction

  function automatic void queue_range(logic [UPTIME_W-1:0] lo, logic [UPTIME_W-1:0] hi);
    item_t it;
    it = noise_item();
    it.kind        = KIND_RANGE;
    it.range_start = lo;
    it.range_end   = hi;
    add_pending(it);
  endfunction

  function automatic void queue_latest(logic [COUNT_W-1:0] cnt);
    item_t it;
    it = noise_item();
    it.kind         = KIND_LATEST;
    it.latest_count = cnt;
    add_pending(it);
  endfunction

  function automatic void queue_clear();
    item_t it;
    it = noise_item();
    it.kind = KIND_CLEAR;
    add_pending(it);
  endfunction

  // Random traffic. Most stores are well-formed records with rising stamps, so the
  // store fills and wraps; the rest break one acceptance rule or use a random stamp.
  // Range windows mostly sit around recent stamps so that they cut into the store.
  function automatic void queue_random_items(int count, int store_pct);
    int                  n;
    int                  pick;
    logic [UPTIME_W-1:0] lo;
    logic [UPTIME_W-1:0] hi;

    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < store_pct) begin
        uptime_clock += $urandom_range(1, 3000);
        if (uptime_clock == 0) uptime_clock = 1;
        case ($urandom_range(0, 9))
          0: queue_store('0, {$urandom, $urandom}, 8'($urandom_range(1, 255)), 1'b1);
          1: queue_store(uptime_clock, {$urandom, $urandom}, '0, 1'b1);
          2: queue_store(uptime_clock, {$urandom, $urandom},
                         8'($urandom_range(1, 255)), 1'b0);
          3: queue_store($urandom, {$urandom, $urandom}, 8'($urandom_range(0, 255)), 1'b1);
          default: queue_store(uptime_clock, {$urandom, $urandom},
                               8'($urandom_range(1, 255)), 1'b1);
        endcase
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          queue_clear();
        end else if (pick <= 10) begin
          case ($urandom_range(0, 7))
            0: queue_range('0, '1);
            1: begin
              // Bounds the wrong way round never match.
              hi = $urandom_range(0, 32'hFFFF_FFFE);
              queue_range(hi + 1, hi);
            end
            2: queue_range($urandom, $urandom);
            default: begin
              hi = uptime_clock - $urandom_range(0, 15000);
              lo = hi - $urandom_range(0, 30000);
              queue_range(lo, hi);
            end
          endcase
        end else begin
          queue_latest(($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 10)));
        end
      end
    end
  endfunction

  // Waits until the driver has nothing left and every expected result has come back,
  // then lets the block settle.
  task automatic wait_drained();
    while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A capacity write empties the store, in the block and in the shadow alike.
  task automatic write_capacity(logic [CAP_W-1:0] value);
    cap_ch.data  <= value;
    cap_ch.valid <= 1'b1;
    do @(posedge clk); while (!cap_ch.ready);
    cap_ch.valid <= 1'b0;
    shadow_cap = value;
    empty_shadow();
  endtask

  // Stimulus: a directed part, then random phases, each under its own capacity. The
  // capacities include zero, one, the depth and values above it, and every bit of the
  // register is seen both low and high.
  logic [CAP_W-1:0] phase_cap [9] = '{7'd1, 7'd0, 7'd127, 7'd3, 7'd100, 7'd2, 7'd64,
                                      7'd5, 7'd37};
  int               phase_len [9] = '{30, 30, 100, 35, 30, 30, 30, 35, 30};

  initial begin
    shadow_cap   = CAP_RESET;
    empty_shadow();
    uptime_clock = $urandom_range(1, 1000);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset capacity. Queries on the empty store come first,
    // then each store rejection rule, records at the field extremes, queries with
    // exact, reversed and extreme bounds, zero and oversized latest counts, and a
    // clear followed by queries on the emptied store.
    queue_range('0, '1);
    queue_latest(7'd5);
    queue_store('0, '1, 8'hFF, 1'b1);
    queue_store(32'd7, '0, 8'h00, 1'b1);
    queue_store(32'd7, '0, 8'h01, 1'b0);
    queue_store(32'd1, '0, 8'h01, 1'b1);
    queue_store('1, '1, 8'hFF, 1'b1);
    queue_store(32'd1000, 64'hA5A5_5A5A_0F0F_F0F0, 8'h80, 1'b1);
    queue_range('0, '1);
    queue_range(32'd1000, 32'd1000);
    queue_range(32'd2000, 32'd1000);
    queue_range('1, '1);
    queue_range('0, '0);
    queue_latest(7'd0);
    queue_latest(7'd2);
    queue_latest(7'd64);
    queue_latest(7'd127);
    queue_clear();
    queue_latest(7'd1);
    queue_range('0, '1);
    wait_drained();

    // A store of two slots: the third record overwrites the first.
    write_capacity(7'd2);
    queue_store(32'd10, 64'h1111_1111_1111_1111, 8'h11, 1'b1);
    queue_store(32'd20, 64'h2222_2222_2222_2222, 8'h22, 1'b1);
    queue_store(32'd30, 64'h3333_3333_3333_3333, 8'h33, 1'b1);
    queue_range('0, '1);
    queue_latest(7'd1);
    queue_latest(7'd5);
    wait_drained();

    // Random phases. The phase with the out-of-range capacity 127 is store-heavy so
    // that the full depth wraps. In every odd-numbered phase the sender also stops halfway
    // until all results are back.
    for (int p = 0; p < 9; p++) begin
      write_capacity(phase_cap[p]);
      queue_random_items(phase_len[p] / 2, (phase_cap[p] == 7'd127) ? 80 : 55);
      if (p % 2 == 1) wait_drained();
      queue_random_items(phase_len[p] - phase_len[p] / 2,
                         (phase_cap[p] == 7'd127) ? 80 : 55);
      wait_drained();
    end

    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every query walking the
  // full depth under the heaviest result stalls.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
